### design/swrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and widths for the sliding-window regression slope core.
// No dependencies; used by the core and its bound checker.

package swrs_pkg;

	// Window length; the sum, product and counter widths follow from it (range 2..64).
	localparam int WINDOW = 5;
	localparam int LOG_N  = $clog2(WINDOW);

	localparam int SMP_W  = 16;                  // sample width
	localparam int Q_W    = 32;                  // slope width, Q16.16
	localparam int FRAC_W = 16;                  // fractional bits of the slope

	localparam int SX_W   = SMP_W + LOG_N;       // sum of samples
	localparam int SS_W   = 2 * SMP_W + LOG_N;   // sum of products
	localparam int PR_W   = 2 * SX_W;            // shared multiplier output
	localparam int ND_W   = 2 * SMP_W + 2 * LOG_N + 1; // numerator / denominator
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int ACC_W  = $clog2(2 * WINDOW);
	localparam int CNT_W  = (ACC_W > $clog2(Q_W)) ? ACC_W : $clog2(Q_W);

	localparam logic [Q_W-1:0] SLOPE_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic [Q_W-1:0] SLOPE_MIN = {1'b1, {(Q_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_FILLING = 2'd0,
		ST_VALID   = 2'd1,
		ST_DEGEN   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_MSX,
		S_MSY,
		S_CHECK,
		S_DIV,
		S_FIN
	} state_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] x_sample;
		logic signed [SMP_W-1:0] y_sample;
	} sample_t;

	typedef struct packed {
		logic signed [Q_W-1:0] slope;
		status_t               status;
	} result_t;

endpackage

`default_nettype wire

### design/sliding_window_regression_slope_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sliding-window least-squares slope core: window store, shared multiplier,
// bit-serial divider and sequencer. Depends on swrs_pkg.
//
// Usage:
//  - sample channel (sample_valid / sample_ready / sample) takes one (x, y) pair
//    per beat. result channel (result_valid / result_ready / result) returns one
//    beat per sample: slope in signed Q16.16 plus a status code.
//  - Until WINDOW pairs have arrived, status is FILLING and slope is zero; the
//    beat that completes the window already carries a computed slope.
//  - All x equal in the window: status DEGEN, slope zero.
//  - Slope is truncated toward zero and saturated at the Q16.16 limits.
// Timing:
//  - Filling beats: the sequencer goes straight from idle to the finish state,
//    which registers the result and returns to idle for the next pair.
//  - Full window: one shared signed multiplier walks the window two products
//    per pair, then forms Sx*Sx and Sx*Sy; a check state follows, then a
//    restoring divider yields one quotient bit per cycle, and the finish
//    state registers the result and returns to idle for the next pair.
//  - Degenerate or out-of-range slope skips the divider: the check state goes
//    straight to the finish state.
//  - sample_ready is high only while the sequencer is idle; one pair is in
//    work at a time.
// Stall: the result sits in an output register, so the next pair is accepted
//  while it waits. A finished slope that finds the register still full holds
//  the sequencer until result_ready frees it.
// Reset (arst_n low): sequencer idle, output empty, window count cleared.

module sliding_window_regression_slope_core (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     sample_valid,
	output logic                    sample_ready,
	input  wire swrs_pkg::sample_t  sample,
	output logic                    result_valid,
	input  wire                     result_ready,
	output swrs_pkg::result_t       result
);

	localparam int WINDOW = swrs_pkg::WINDOW;
	localparam int SMP_W  = swrs_pkg::SMP_W;
	localparam int SX_W   = swrs_pkg::SX_W;
	localparam int SS_W   = swrs_pkg::SS_W;
	localparam int PR_W   = swrs_pkg::PR_W;
	localparam int ND_W   = swrs_pkg::ND_W;
	localparam int Q_W    = swrs_pkg::Q_W;
	localparam int FRAC_W = swrs_pkg::FRAC_W;
	localparam int FILL_W = swrs_pkg::FILL_W;
	localparam int CNT_W  = swrs_pkg::CNT_W;

	localparam logic signed [ND_W-1:0] WIN_S = ND_W'(WINDOW);

	// Sequencer
	swrs_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [FILL_W-1:0] fill_q;

	// Window store: a shift line, rotated in place while it is summed
	logic signed [SMP_W-1:0] x_win_q [WINDOW];
	logic signed [SMP_W-1:0] y_win_q [WINDOW];

	// Accumulators and intermediate terms
	logic signed [SX_W-1:0] sx_q, sy_q;
	logic signed [SS_W-1:0] sxx_q, sxy_q;
	logic signed [ND_W-1:0] num_q, den_q;

	// Divider
	logic [ND_W-1:0] rem_q;
	logic [Q_W-1:0]  quo_q;     // low dividend bits shift out, quotient bits in
	logic            neg_q;
	logic            ovf_q;
	swrs_pkg::status_t status_q;

	// Output register
	logic               result_valid_q;
	swrs_pkg::result_t  result_q;

	// Control decode
	logic                   accept;
	logic                   out_free;
	logic                   full_next;
	logic                   acc_last;
	logic                   div_last;
	logic signed [SX_W-1:0] mul_a, mul_b;
	logic signed [PR_W-1:0] prod;
	logic signed [ND_W-1:0] prod_ext;
	logic [ND_W-1:0]        mag_c;
	logic [ND_W-1:0]        mag_hi;
	logic                   den_pos;
	logic                   ovf_c;
	logic [ND_W:0]          rem_shift;
	logic [ND_W:0]          rem_diff;
	logic                   qbit;
	logic [Q_W-1:0]         slope_c;

	assign accept    = sample_valid && sample_ready;
	assign out_free  = !result_valid_q || result_ready;
	assign full_next = (fill_q >= FILL_W'(WINDOW - 1));
	assign acc_last  = (cnt_q == CNT_W'(2 * WINDOW - 1));
	assign div_last  = (cnt_q == CNT_W'(Q_W - 1));

	// Shared signed multiplier
	assign prod     = mul_a * mul_b;
	assign prod_ext = ND_W'(prod);

	// Magnitude of the numerator and early overflow test: the quotient
	// (|num| << 16) / den fits 32 bits only if (|num| >> 16) < den.
	assign mag_c   = num_q[ND_W-1] ? (~$unsigned(num_q) + 1'b1) : $unsigned(num_q);
	assign mag_hi  = mag_c >> FRAC_W;
	assign den_pos = !den_q[ND_W-1] && (den_q != '0);
	assign ovf_c   = (mag_hi >= $unsigned(den_q));

	// One restoring division step
	assign rem_shift = {rem_q, quo_q[Q_W-1]};
	assign rem_diff  = rem_shift - {1'b0, $unsigned(den_q)};
	assign qbit      = (rem_shift >= {1'b0, $unsigned(den_q)});

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			swrs_pkg::S_IDLE: begin
				if (accept) begin
					state_d = full_next ? swrs_pkg::S_ACC : swrs_pkg::S_FIN;
				end
			end
			swrs_pkg::S_ACC: begin
				if (acc_last) begin
					state_d = swrs_pkg::S_MSX;
				end
			end
			swrs_pkg::S_MSX: state_d = swrs_pkg::S_MSY;
			swrs_pkg::S_MSY: state_d = swrs_pkg::S_CHECK;
			swrs_pkg::S_CHECK: begin
				if (!den_pos || ovf_c) begin
					state_d = swrs_pkg::S_FIN;
				end else begin
					state_d = swrs_pkg::S_DIV;
				end
			end
			swrs_pkg::S_DIV: begin
				if (div_last) begin
					state_d = swrs_pkg::S_FIN;
				end
			end
			swrs_pkg::S_FIN: begin
				if (out_free) begin
					state_d = swrs_pkg::S_IDLE;
				end
			end
			default: state_d = swrs_pkg::S_IDLE;
		endcase
	end

	// State-decoded controls: handshake and multiplier operands
	always_comb begin
		sample_ready = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		case (state_q)
			swrs_pkg::S_IDLE: sample_ready = 1'b1;
			swrs_pkg::S_ACC: begin
				// even step: x*x, odd step: x*y, always on the head of the window
				mul_a = SX_W'(x_win_q[0]);
				mul_b = cnt_q[0] ? SX_W'(y_win_q[0]) : SX_W'(x_win_q[0]);
			end
			swrs_pkg::S_MSX: begin
				mul_a = sx_q;
				mul_b = sx_q;
			end
			swrs_pkg::S_MSY: begin
				mul_a = sx_q;
				mul_b = sy_q;
			end
			default: begin
				sample_ready = 1'b0;
			end
		endcase
	end

	// Final slope: zero unless the status is valid, else saturate and apply sign
	always_comb begin
		if (status_q != swrs_pkg::ST_VALID) begin
			slope_c = '0;
		end else if (ovf_q) begin
			slope_c = neg_q ? swrs_pkg::SLOPE_MIN : swrs_pkg::SLOPE_MAX;
		end else if (neg_q) begin
			slope_c = quo_q[Q_W-1] ? swrs_pkg::SLOPE_MIN : (~quo_q + 1'b1);
		end else begin
			slope_c = quo_q[Q_W-1] ? swrs_pkg::SLOPE_MAX : quo_q;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= swrs_pkg::S_IDLE;
			fill_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && (fill_q != FILL_W'(WINDOW))) begin
				fill_q <= fill_q + 1'b1;
			end
			if ((state_q == swrs_pkg::S_FIN) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			swrs_pkg::S_IDLE: begin
				if (accept) begin
					for (int i = 0; i < WINDOW - 1; i++) begin
						x_win_q[i] <= x_win_q[i+1];
						y_win_q[i] <= y_win_q[i+1];
					end
					x_win_q[WINDOW-1] <= sample.x_sample;
					y_win_q[WINDOW-1] <= sample.y_sample;
					sx_q     <= '0;
					sy_q     <= '0;
					sxx_q    <= '0;
					sxy_q    <= '0;
					cnt_q    <= '0;
					ovf_q    <= 1'b0;
					status_q <= full_next ? swrs_pkg::ST_VALID : swrs_pkg::ST_FILLING;
				end
			end
			swrs_pkg::S_ACC: begin
				cnt_q <= cnt_q + 1'b1;
				if (!cnt_q[0]) begin
					sxx_q <= sxx_q + SS_W'(prod);
				end else begin
					sxy_q <= sxy_q + SS_W'(prod);
					sx_q  <= sx_q + SX_W'(x_win_q[0]);
					sy_q  <= sy_q + SX_W'(y_win_q[0]);
					// rotate one place; after WINDOW rotations the order is restored
					for (int i = 0; i < WINDOW - 1; i++) begin
						x_win_q[i] <= x_win_q[i+1];
						y_win_q[i] <= y_win_q[i+1];
					end
					x_win_q[WINDOW-1] <= x_win_q[0];
					y_win_q[WINDOW-1] <= y_win_q[0];
				end
			end
			swrs_pkg::S_MSX: begin
				den_q <= WIN_S * ND_W'(sxx_q) - prod_ext;
			end
			swrs_pkg::S_MSY: begin
				num_q <= WIN_S * ND_W'(sxy_q) - prod_ext;
			end
			swrs_pkg::S_CHECK: begin
				cnt_q <= '0;
				neg_q <= num_q[ND_W-1];
				ovf_q <= ovf_c;
				rem_q <= mag_hi;
				quo_q <= {mag_c[FRAC_W-1:0], {(Q_W-FRAC_W){1'b0}}};
				if (!den_pos) begin
					status_q <= swrs_pkg::ST_DEGEN;
				end
			end
			swrs_pkg::S_DIV: begin
				cnt_q <= cnt_q + 1'b1;
				rem_q <= qbit ? rem_diff[ND_W-1:0] : rem_shift[ND_W-1:0];
				quo_q <= {quo_q[Q_W-2:0], qbit};
			end
			swrs_pkg::S_FIN: begin
				if (out_free) begin
					result_q.slope  <= $signed(slope_c);
					result_q.status <= status_q;
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

### design/swrs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the slope core, bound to the top level.
// Depends on swrs_pkg and sliding_window_regression_slope_core.

module swrs_checker (
	input wire                     clk,
	input wire                     arst_n,
	input wire                     sample_valid,
	input wire                     sample_ready,
	input wire swrs_pkg::sample_t  sample,
	input wire                     result_valid,
	input wire                     result_ready,
	input wire swrs_pkg::result_t  result
);

	// one pair in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sample_ready) |=> !sample_ready)
		else $error("sample_ready stayed high after an accepted beat");

	// a fresh result releases the sequencer at once
	a_idle_on_new_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> sample_ready)
		else $error("new result while the core is still busy");

	// filling and degenerate beats carry a zero slope
	a_zero_slope: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.status != swrs_pkg::ST_VALID)) |-> (result.slope == '0))
		else $error("nonzero slope with filling or degenerate status");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result)))
		else $error("stalled result changed or dropped");

endmodule

bind sliding_window_regression_slope_core swrs_checker u_swrs_checker (.*);

`default_nettype wire
